// ----- sv/ese_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ese_pkg
// Shared widths, control word layout and microcode store for the encoder
// speed estimator.
// ----------------------------------------------------------------------------
package ese_pkg;

    localparam int GAIN_W  = 16;
    localparam int ALPHA_W = 17;
    localparam int RAW_W   = 22;
    localparam int FV_W    = 38;
    localparam int MA_W    = 23;
    localparam int MB_W    = 18;
    localparam int P_W     = MA_W + MB_W;
    localparam int ACC_W   = 40;
    localparam int STEP_W  = 2;

    localparam int RAW_MAX = 2 ** (RAW_W - 1) - 1;
    localparam int RAW_MIN = -(2 ** (RAW_W - 1));

    localparam logic [ALPHA_W-1:0] ONE_Q16 = ALPHA_W'(65536);

    localparam logic [GAIN_W-1:0]  GAIN_RESET  = GAIN_W'(94);
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(6554);

    // register indexes
    localparam logic CFG_SPEED_GAIN   = 1'b0;
    localparam logic CFG_FILTER_ALPHA = 1'b1;

    // multiplier operand A
    localparam logic [1:0] A_DELTA = 2'd0;
    localparam logic [1:0] A_FLO   = 2'd1;
    localparam logic [1:0] A_FHI   = 2'd2;
    localparam logic [1:0] A_RAW   = 2'd3;

    // multiplier operand B
    localparam logic [1:0] B_GAIN      = 2'd0;
    localparam logic [1:0] B_ONE_MINUS = 2'd1;
    localparam logic [1:0] B_ALPHA     = 2'd2;

    // accumulator ops
    localparam logic [1:0] ACC_HOLD  = 2'd0;
    localparam logic [1:0] ACC_LOAD  = 2'd1;
    localparam logic [1:0] ACC_ADD   = 2'd2;

    // jump conditions
    localparam logic JC_NEXT     = 1'b0;
    localparam logic JC_OUT_FREE = 1'b1;

    // step addresses
    localparam logic [STEP_W-1:0] STEP_DELTA = 2'd0;
    localparam logic [STEP_W-1:0] STEP_GAIN  = 2'd1;
    localparam logic [STEP_W-1:0] STEP_HIGH  = 2'd2;
    localparam logic [STEP_W-1:0] STEP_ALPHA = 2'd3;

    typedef struct packed {
        logic [1:0]        a_sel;
        logic [1:0]        b_sel;
        logic [1:0]        acc_op;
        logic              ld_delta;
        logic              ld_tmp;
        logic              ld_raw;
        logic              finish;
        logic              jmp_cond;
        logic [STEP_W-1:0] jmp_target;
    } ese_ctrl_t;

    localparam ese_ctrl_t CTRL_NOP = '{
        a_sel: A_DELTA, b_sel: B_GAIN, acc_op: ACC_HOLD,
        ld_delta: 1'b0, ld_tmp: 1'b0, ld_raw: 1'b0, finish: 1'b0,
        jmp_cond: JC_NEXT, jmp_target: STEP_DELTA
    };

    // Program:
    //   DELTA: wrap angle change;       acc  = (1-a)*f_lo >> 16
    //   GAIN : tmp  = delta*gain
    //   HIGH : raw  = sat(tmp >>> 8);   acc += (1-a)*f_hi
    //   ALPHA: acc += a*raw; write back, jump to DELTA once output is free
    function automatic ese_ctrl_t ese_rom(input logic [STEP_W-1:0] step);
        ese_ctrl_t c;
        c = CTRL_NOP;
        case (step)
            STEP_DELTA:
            begin
                c.a_sel    = A_FLO;
                c.b_sel    = B_ONE_MINUS;
                c.acc_op   = ACC_LOAD;
                c.ld_delta = 1'b1;
            end
            STEP_GAIN:
            begin
                c.a_sel  = A_DELTA;
                c.b_sel  = B_GAIN;
                c.ld_tmp = 1'b1;
            end
            STEP_HIGH:
            begin
                c.a_sel  = A_FHI;
                c.b_sel  = B_ONE_MINUS;
                c.acc_op = ACC_ADD;
                c.ld_raw = 1'b1;
            end
            STEP_ALPHA:
            begin
                c.a_sel      = A_RAW;
                c.b_sel      = B_ALPHA;
                c.acc_op     = ACC_ADD;
                c.finish     = 1'b1;
                c.jmp_cond   = JC_OUT_FREE;
                c.jmp_target = STEP_DELTA;
            end
            default:
            begin
                c = CTRL_NOP;
            end
        endcase
        return c;
    endfunction

endpackage

// ----- sv/ese_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ese_sequencer
// Step counter over the microcode store; issues one control word per cycle
// while busy and not held by a stalled output, and owns the input handshake.
// ----------------------------------------------------------------------------
module ese_sequencer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              out_free,
    output logic              in_ready,
    output ese_pkg::ese_ctrl_t ctrl
);
    import ese_pkg::*;

    logic              busy_reg;
    logic              busy_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    ese_ctrl_t         word;
    logic              cond_ok;
    logic              start;

    assign word    = ese_rom(step_reg);
    assign cond_ok = (word.jmp_cond == JC_NEXT) || out_free;

    // next transaction may land on the edge that retires the current one
    assign in_ready = !busy_reg || (word.finish && cond_ok);
    assign start    = in_valid && in_ready;

    assign ctrl = (busy_reg && cond_ok) ? word : CTRL_NOP;

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (!busy_reg)
        begin
            busy_next = start;
            step_next = STEP_DELTA;
        end
        else if (cond_ok)
        begin
            if (word.jmp_cond == JC_NEXT)
                step_next = step_reg + STEP_W'(1);
            else
                step_next = word.jmp_target;
            if (word.finish)
                busy_next = start;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= STEP_DELTA;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

endmodule

// ----- sv/encoder_speed_estimator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_speed_estimator
// Per-channel angle assembly, wrapped delta, gain scaling and EMA smoothing.
// ----------------------------------------------------------------------------
// Each reading runs a four-step microcode program that drives one
// shared 23x18 signed multiplier (delta*gain, two partial products of the
// filter state times 1-alpha, alpha*raw). A new reading is accepted on the
// cycle the previous one retires into the output register, so back-to-back
// readings run with no idle step between them while results are drained promptly; a
// stalled output holds the last step. Angle and filter state are kept per
// channel and clear to zero on reset, so the first reading may show a jump.
module encoder_speed_estimator #(
    parameter int CHANNELS   = 2,
    parameter int ANGLE_BITS = 14
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         channel,
    input  logic [7:0]                   angle_high_byte,
    input  logic [7:0]                   angle_low_byte,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         channel_out,
    output logic [ANGLE_BITS-1:0]        angle_counts,
    output logic signed [21:0]           raw_speed,
    output logic signed [21:0]           smoothed_speed,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_index,
    input  logic [16:0]                  cfg_data
);
    import ese_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DW   = ANGLE_BITS + 1;
    localparam int DW2  = ANGLE_BITS + 2;
    localparam logic signed [DW2-1:0] FULL = DW2'(2 ** ANGLE_BITS);
    localparam logic signed [DW2-1:0] HALF = DW2'(2 ** (ANGLE_BITS - 1));

    // configuration
    logic [GAIN_W-1:0]  speed_gain_reg;
    logic [ALPHA_W-1:0] filter_alpha_reg;

    // per-channel state
    logic [ANGLE_BITS-1:0] prev_angle_reg [CHANNELS];
    logic signed [FV_W-1:0] filter_value_reg [CHANNELS];

    // working registers
    logic [CH_W-1:0]        ch_reg;
    logic [ANGLE_BITS-1:0]  angle_reg;
    logic signed [DW-1:0]   delta_reg;
    logic signed [P_W-1:0]  tmp_reg;
    logic signed [RAW_W-1:0] raw_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;

    // output register
    logic                    out_valid_reg;
    logic                    channel_out_reg;
    logic [ANGLE_BITS-1:0]   angle_counts_reg;
    logic signed [RAW_W-1:0] raw_speed_reg;
    logic signed [RAW_W-1:0] smoothed_speed_reg;

    ese_ctrl_t ctrl;
    logic      out_free;
    logic      start;

    logic [15:0]             byte_pair;
    logic [ANGLE_BITS-1:0]   angle_in;
    logic [CH_W-1:0]         ch_in;
    logic [ANGLE_BITS-1:0]   prev_cur;
    logic signed [FV_W-1:0]  fv_cur;
    logic signed [DW2-1:0]   diff;
    logic signed [DW2-1:0]   wrapped;
    logic [ALPHA_W-1:0]      alpha_eff;
    logic [ALPHA_W-1:0]      one_minus_a;
    logic signed [MA_W-1:0]  mul_a;
    logic signed [MB_W-1:0]  mul_b;
    logic signed [P_W-1:0]   prod;
    logic signed [P_W-1:0]   scaled;
    logic signed [P_W-1:0]   sat_hi;
    logic signed [P_W-1:0]   sat_lo;
    logic signed [RAW_W-1:0] raw_sat;

    assign out_free  = !out_valid_reg || out_ready;
    assign start     = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    ese_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_free (out_free),
        .in_ready (in_ready),
        .ctrl     (ctrl)
    );

    // angle = high bits from the first byte, low bits from the top of the second
    assign byte_pair = {angle_high_byte, angle_low_byte};
    assign angle_in  = ANGLE_BITS'(byte_pair >> (16 - ANGLE_BITS));
    assign ch_in     = (CHANNELS > 1) ? CH_W'(channel) : '0;

    assign prev_cur = prev_angle_reg[ch_reg];
    assign fv_cur   = filter_value_reg[ch_reg];

    always_comb
    begin
        diff = $signed(DW2'(angle_reg)) - $signed(DW2'(prev_cur));
        if (diff > HALF)
            wrapped = diff - FULL;
        else if (diff < -HALF)
            wrapped = diff + FULL;
        else
            wrapped = diff;
    end

    assign alpha_eff   = (filter_alpha_reg > ONE_Q16) ? ONE_Q16 : filter_alpha_reg;
    assign one_minus_a = ONE_Q16 - alpha_eff;

    always_comb
    begin
        case (ctrl.a_sel)
            A_DELTA: mul_a = MA_W'(delta_reg);
            A_FLO:   mul_a = $signed(MA_W'(fv_cur[15:0]));
            A_FHI:   mul_a = MA_W'($signed(fv_cur[FV_W-1:16]));
            A_RAW:   mul_a = MA_W'(raw_reg);
            default: mul_a = '0;
        endcase
        case (ctrl.b_sel)
            B_GAIN:      mul_b = $signed(MB_W'(speed_gain_reg));
            B_ONE_MINUS: mul_b = $signed(MB_W'(one_minus_a));
            B_ALPHA:     mul_b = $signed(MB_W'(alpha_eff));
            default:     mul_b = '0;
        endcase
    end

    assign prod = mul_a * mul_b;

    always_comb
    begin
        case (ctrl.acc_op)
            ACC_LOAD: acc_next = ACC_W'(prod >>> 16);
            ACC_ADD:  acc_next = acc_reg + ACC_W'(prod);
            default:  acc_next = acc_reg;
        endcase
    end

    // floor(delta*gain / 256), clamped to the raw speed range
    assign scaled = tmp_reg >>> 8;
    assign sat_hi = P_W'(RAW_MAX);
    assign sat_lo = P_W'(RAW_MIN);
    always_comb
    begin
        if (scaled > sat_hi)
            raw_sat = RAW_W'(sat_hi);
        else if (scaled < sat_lo)
            raw_sat = RAW_W'(sat_lo);
        else
            raw_sat = RAW_W'(scaled);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_gain_reg   <= GAIN_RESET;
            filter_alpha_reg <= ALPHA_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SPEED_GAIN:   speed_gain_reg   <= cfg_data[GAIN_W-1:0];
                CFG_FILTER_ALPHA: filter_alpha_reg <= cfg_data;
                default:          speed_gain_reg   <= speed_gain_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                prev_angle_reg[i]   <= '0;
                filter_value_reg[i] <= '0;
            end
        end
        else if (ctrl.finish)
        begin
            prev_angle_reg[ch_reg]   <= angle_reg;
            filter_value_reg[ch_reg] <= FV_W'(acc_next);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ch_reg    <= ch_in;
            angle_reg <= angle_in;
        end
        if (ctrl.ld_delta)
            delta_reg <= DW'(wrapped);
        if (ctrl.ld_tmp)
            tmp_reg <= prod;
        if (ctrl.ld_raw)
            raw_reg <= raw_sat;
        acc_reg <= acc_next;
        if (ctrl.finish)
        begin
            channel_out_reg    <= ch_reg[0];
            angle_counts_reg   <= angle_reg;
            raw_speed_reg      <= raw_reg;
            smoothed_speed_reg <= acc_next[16 +: RAW_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctrl.finish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_valid      = out_valid_reg;
    assign channel_out    = channel_out_reg;
    assign angle_counts   = angle_counts_reg;
    assign raw_speed      = raw_speed_reg;
    assign smoothed_speed = smoothed_speed_reg;

endmodule
